// ----- src/potimer_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the timer table.
// No dependencies; every other file of the block uses this package.
package potimer_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 31;
  localparam int REM_W  = 32;

  // Operation codes of an input item
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] interval;
    logic              repeating;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
    logic            last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CREATE_END,
    S_DELETE_END,
    S_SORT,
    S_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic sort_mode;
    logic finish_create;
    logic finish_delete;
    logic emit_fired;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic [1:0] op;
    logic       none_fired;
    logic       one_left;
  } dp_stat_t;

  // Signed subtract, saturating at the most negative value
  function automatic logic [REM_W-1:0] sat_sub(input logic [REM_W-1:0] rem,
                                               input logic [TIME_W-1:0] dt);
    logic [REM_W:0] diff;
    diff = {rem[REM_W-1], rem} - {{(REM_W+1-TIME_W){1'b0}}, dt};
    if (diff[REM_W] != diff[REM_W-1]) begin
      return REM_MIN;
    end
    return diff[REM_W-1:0];
  endfunction

  function automatic logic is_nonpositive(input logic [REM_W-1:0] rem);
    return (rem == '0) || rem[REM_W-1];
  endfunction

endpackage

// ----- src/potimer_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the timer table: scan, finish and sort/emit phases.
// Depends on potimer_pkg; drives the datapath potimer_dp by command struct.
module potimer_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  potimer_pkg::dp_stat_t stat,
  output potimer_pkg::dp_cmd_t  ctl
);

  potimer_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= potimer_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      potimer_pkg::S_IDLE: begin
        if (start) begin
          ctl.load       = 1'b1;
          ctl.scan_start = 1'b1;
          state_next     = potimer_pkg::S_SCAN;
        end
      end
      potimer_pkg::S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_done) begin
          unique case (stat.op)
            potimer_pkg::OP_CREATE: state_next = potimer_pkg::S_CREATE_END;
            potimer_pkg::OP_DELETE: state_next = potimer_pkg::S_DELETE_END;
            potimer_pkg::OP_TICK: begin
              if (stat.none_fired) begin
                state_next = potimer_pkg::S_IDLE;
              end else begin
                ctl.scan_start = 1'b1;
                state_next     = potimer_pkg::S_SORT;
              end
            end
            default: state_next = potimer_pkg::S_IDLE;
          endcase
        end
      end
      potimer_pkg::S_CREATE_END: begin
        ctl.finish_create = 1'b1;
        state_next        = potimer_pkg::S_IDLE;
      end
      potimer_pkg::S_DELETE_END: begin
        ctl.finish_delete = 1'b1;
        state_next        = potimer_pkg::S_IDLE;
      end
      potimer_pkg::S_SORT: begin
        ctl.scan_step = 1'b1;
        ctl.sort_mode = 1'b1;
        if (stat.scan_done) begin
          state_next = potimer_pkg::S_EMIT;
        end
      end
      potimer_pkg::S_EMIT: begin
        ctl.emit_fired = 1'b1;
        if (stat.one_left) begin
          state_next = potimer_pkg::S_IDLE;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = potimer_pkg::S_SORT;
        end
      end
      default: state_next = potimer_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != potimer_pkg::S_IDLE);

endmodule

// ----- src/potimer_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the timer table: slot memories, valid and fired bits, the
// slot scan pipeline, the id counter and the result register. Uses potimer_pkg.
module potimer_dp #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  potimer_pkg::item_t    cmd,
  input  potimer_pkg::dp_cmd_t  ctl,
  output potimer_pkg::dp_stat_t stat,
  output logic                  strobe,
  output potimer_pkg::result_t  result
);

  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TIMERS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Slot memories, read at the scan address with registered data
  logic [potimer_pkg::ID_W-1:0]   mem_ident  [MAX_TIMERS];
  logic [potimer_pkg::TIME_W-1:0] mem_reload [MAX_TIMERS];
  logic [potimer_pkg::REM_W-1:0]  mem_rem    [MAX_TIMERS];
  logic                           mem_per    [MAX_TIMERS];

  potimer_pkg::item_t item_q;

  logic [CNT_W-1:0]               cnt;
  logic                           p_vld;
  logic [IDX_W-1:0]               p_idx;
  logic [potimer_pkg::ID_W-1:0]   rd_ident;
  logic [potimer_pkg::TIME_W-1:0] rd_reload;
  logic [potimer_pkg::REM_W-1:0]  rd_rem;
  logic                           rd_per;

  logic [MAX_TIMERS-1:0]          valid;
  logic [MAX_TIMERS-1:0]          fired;
  logic [CNT_W-1:0]               nfired;
  logic                           found;
  logic [IDX_W-1:0]               found_idx;
  logic                           best_vld;
  logic [potimer_pkg::ID_W-1:0]   best_id;
  logic [IDX_W-1:0]               best_idx;
  logic [potimer_pkg::ID_W-1:0]   id_counter;

  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic                           proc;
  logic                           create_hit;
  logic                           delete_hit;
  logic                           do_tick;
  logic [potimer_pkg::REM_W-1:0]  tick_rem;
  logic                           tick_fire;
  logic                           sort_hit;
  logic [potimer_pkg::ID_W-1:0]   next_id;

  assign rd_en   = ctl.scan_step && (cnt != CNT_END);
  assign rd_addr = cnt[IDX_W-1:0];
  assign proc    = p_vld && !ctl.sort_mode;

  assign create_hit = proc && (item_q.operation == potimer_pkg::OP_CREATE) &&
                      !valid[p_idx] && !found;
  assign delete_hit = proc && (item_q.operation == potimer_pkg::OP_DELETE) &&
                      valid[p_idx] && (rd_ident == item_q.timer_id) && !found;
  assign do_tick    = proc && (item_q.operation == potimer_pkg::OP_TICK) &&
                      valid[p_idx];
  assign tick_rem   = potimer_pkg::sat_sub(rd_rem, item_q.elapsed);
  assign tick_fire  = potimer_pkg::is_nonpositive(tick_rem);
  // Strict compare keeps the lower slot on equal identifiers
  assign sort_hit   = p_vld && ctl.sort_mode && fired[p_idx] &&
                      (!best_vld || (rd_ident < best_id));
  assign next_id    = id_counter + 1'b1;

  // Memory read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ident  <= mem_ident[rd_addr];
      rd_reload <= mem_reload[rd_addr];
      rd_rem    <= mem_rem[rd_addr];
      rd_per    <= mem_per[rd_addr];
    end
  end

  // Memory write port: new timer on create, countdown update on tick
  always_ff @(posedge clk) begin
    if (ctl.finish_create && found) begin
      mem_ident[found_idx]  <= next_id;
      mem_reload[found_idx] <= item_q.interval;
      mem_rem[found_idx]    <= {1'b0, item_q.interval};
      mem_per[found_idx]    <= item_q.repeating;
    end else if (do_tick) begin
      mem_rem[p_idx] <= (tick_fire && rd_per) ? {1'b0, rd_reload} : tick_rem;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      p_vld      <= 1'b0;
      valid      <= '0;
      fired      <= '0;
      nfired     <= '0;
      found      <= 1'b0;
      best_vld   <= 1'b0;
      id_counter <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= ctl.finish_create || ctl.finish_delete || ctl.emit_fired;
      if (ctl.load) begin
        fired  <= '0;
        nfired <= '0;
      end
      if (ctl.scan_step) begin
        p_vld <= rd_en;
        if (rd_en) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (create_hit || delete_hit) begin
        found <= 1'b1;
      end
      if (do_tick && tick_fire) begin
        fired[p_idx] <= 1'b1;
        nfired       <= nfired + 1'b1;
        if (!rd_per) begin
          valid[p_idx] <= 1'b0;
        end
      end
      if (sort_hit) begin
        best_vld <= 1'b1;
      end
      if (ctl.finish_create && found) begin
        valid[found_idx] <= 1'b1;
        id_counter       <= next_id;
      end
      if (ctl.finish_delete && found) begin
        valid[found_idx] <= 1'b0;
      end
      if (ctl.emit_fired) begin
        fired[best_idx] <= 1'b0;
        nfired          <= nfired - 1'b1;
      end
      // Restart the scan last so it wins over the final step
      if (ctl.scan_start) begin
        cnt      <= '0;
        p_vld    <= 1'b0;
        found    <= 1'b0;
        best_vld <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= cmd;
    end
    if (ctl.scan_step) begin
      p_idx <= rd_addr;
    end
    if (create_hit || delete_hit) begin
      found_idx <= p_idx;
    end
    if (sort_hit) begin
      best_id  <= rd_ident;
      best_idx <= p_idx;
    end
    if (ctl.finish_create) begin
      result.kind      <= potimer_pkg::KIND_CREATE;
      result.result_id <= found ? next_id : '0;
      result.status    <= found ? potimer_pkg::STAT_OK : potimer_pkg::STAT_FULL;
      result.last      <= 1'b1;
    end else if (ctl.finish_delete) begin
      result.kind      <= potimer_pkg::KIND_DELETE;
      result.result_id <= item_q.timer_id;
      result.status    <= found ? potimer_pkg::STAT_OK : potimer_pkg::STAT_NOT_FOUND;
      result.last      <= 1'b1;
    end else if (ctl.emit_fired) begin
      result.kind      <= potimer_pkg::KIND_FIRED;
      result.result_id <= best_id;
      result.status    <= potimer_pkg::STAT_OK;
      result.last      <= (nfired == CNT_ONE);
    end
  end

  assign stat.scan_done  = (cnt == CNT_END) && !p_vld;
  assign stat.op         = item_q.operation;
  assign stat.none_fired = (nfired == '0);
  assign stat.one_left   = (nfired == CNT_ONE);

endmodule

// ----- src/periodic_oneshot_timer_table_unit.sv -----
`timescale 1ns / 1ps
// Top level of the timer table: controller potimer_ctrl plus datapath potimer_dp.
// Depends on potimer_pkg for the item, result and command types.
//
// Table of up to MAX_TIMERS software timers. Raise start with an item on cmd
// while busy is low; the item is taken at that clock edge. Every item walks
// the slot table one slot per cycle through a single read port of the slot
// memories. A create or delete item gives exactly one result. A tick first
// updates every slot, then emits the fired timers in ascending identifier
// order, one selection scan per fired timer; a tick that fires nothing gives
// no result. Each result shows on result for exactly one cycle with strobe
// high, and last marks the final result of its item. The receiver cannot
// stall: capture result whenever strobe is high. busy drops in the cycle that
// shows the final result, so the next item may be taken at the edge that
// ends it. Operation code 3 is scanned over and dropped without a result.
module periodic_oneshot_timer_table_unit #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  potimer_pkg::item_t   cmd,
  output logic                 strobe,
  output potimer_pkg::result_t result
);

  potimer_pkg::dp_cmd_t  ctl;
  potimer_pkg::dp_stat_t stat;

  // Sequence scan, finish, sort and emit phases
  potimer_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Hold the slots, advance the scan, register each result with a one-cycle strobe
  potimer_dp #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ----- src/potimer_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the timer table, bound to the top level.
// Depends on potimer_pkg for the result type and codes.
module potimer_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 strobe,
  input potimer_pkg::result_t result
);

  // A taken item always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  // More results of the same item follow while the block stays busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy)
    else $error("block idle while a tick still has results");

  // Create and delete items answer with a single result
  a_single_answer: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.kind != potimer_pkg::KIND_FIRED)) |-> result.last)
    else $error("create or delete answer not marked last");

  // A final result is never directly followed by another
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("result right after a final result");

endmodule

bind periodic_oneshot_timer_table_unit potimer_chk u_potimer_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
